// ===== design/circular_deque_top_defines.svh =====
// ----------------------------------------------------------------------------
// circular_deque_top_defines.svh
// Assertion macros used by the circular deque checker.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_DEQUE_TOP_DEFINES_SVH
`define CIRCULAR_DEQUE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CDQ_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("circular deque check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CDQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("circular deque check failed");

`endif

// ===== design/cdq_pkg.sv =====
// ----------------------------------------------------------------------------
// cdq_pkg
// Types and constants for the circular deque.
// ----------------------------------------------------------------------------
package cdq_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CMD_W     = 3;
  localparam int unsigned STAT_W    = 2;
  localparam int unsigned M_TDATA_W = 104;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_REAR  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_REAR   = 3'd3,
    CMD_QUERY      = 3'd4
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE       = 2'd0,
    STAT_FULL       = 2'd1,
    STAT_POP_EMPTY  = 2'd2
  } status_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } state_e;

  // Result item, laid out as on m_axis_tdata (last member in the lowest bits).
  typedef struct packed {
    logic [3:0]        pad;
    logic              is_empty;
    logic              is_full;
    logic [DATA_W-1:0] rear_value;
    logic [DATA_W-1:0] front_value;
    logic [DATA_W-1:0] popped_value;
    status_e           status;
  } res_t;

endpackage

// ===== design/circular_deque_top.sv =====
// Push, query, refused op, pop of the last element: result registered on accept.
// Pop leaving elements behind: slot memory read of the new end, then result registered.
// Throughput: 1 item per cycle for pushes and queries unless the result side stalls;
//   such a pop holds off new items until the read is done and its result is loaded.
// Reset: asynchronous, active low; deque empty, indices zero, no result pending.
// ----------------------------------------------------------------------------
// circular_deque_top
// Double-ended queue in a circular slot memory with wrapping front and rear
// indices. Front and rear values are cached in registers; a pop that leaves
// elements refetches the new end element from memory. One result item per input item.
// ----------------------------------------------------------------------------
module circular_deque_top
  import cdq_pkg::*;
#(
  parameter int unsigned DEPTH = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Input items
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [DATA_W-1:0]    s_axis_tdata,   // [31:0] data_in
  input  logic [CMD_W-1:0]     s_axis_tuser,   // [2:0] cmd
  // Result items
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [1:0] status, [33:2] popped_value, [65:34] front_value,
  // [97:66] rear_value, [98] is_full, [99] is_empty, [103:100] zero
  output logic [M_TDATA_W-1:0] m_axis_tdata
);

  localparam int unsigned IDX_W = $clog2(DEPTH);

  // Wrap helpers for arbitrary depth.
  function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(DEPTH - 1)) ? '0 : IDX_W'(i + 1'b1);
  endfunction

  function automatic logic [IDX_W-1:0] idx_prev(input logic [IDX_W-1:0] i);
    return (i == '0) ? IDX_W'(DEPTH - 1) : IDX_W'(i - 1'b1);
  endfunction

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  state_e            state_q, state_d;
  logic [IDX_W-1:0]  front_idx_q, front_idx_d;
  logic [IDX_W-1:0]  rear_idx_q, rear_idx_d;
  logic              empty_q, empty_d;
  logic [DATA_W-1:0] front_val_q, front_val_d;   // cached slot at front index
  logic [DATA_W-1:0] rear_val_q, rear_val_d;     // cached slot at rear index
  logic [DATA_W-1:0] popped_q, popped_d;         // value held across the read
  logic              pop_front_q, pop_front_d;   // side of the pending pop
  logic              m_valid_q, m_valid_d;
  res_t              res_q, res_d;

  // Slot memory: one write port, one registered read port.
  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rd_data_q;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;

  // Control
  logic              out_free;
  logic              accept;
  logic              need_read;
  logic              res_load;
  status_e           res_status;
  cmd_e              cmd;
  logic [DATA_W-1:0] data_in;

  assign cmd     = cmd_e'(s_axis_tuser);
  assign data_in = s_axis_tdata;

  // Output stage is free when empty or being drained this cycle.
  assign out_free = !m_valid_q || m_axis_tready;
  assign accept   = s_axis_tvalid && s_axis_tready;

  // --------------------------------------------------------------------------
  // FSM: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && need_read) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // FSM: outputs
  // --------------------------------------------------------------------------
  always_comb begin
    s_axis_tready = 1'b0;
    unique case (state_q)
      ST_IDLE: s_axis_tready = out_free;
      ST_READ: s_axis_tready = 1'b0;
      default: s_axis_tready = 1'b0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath: update indices, cached ends and memory; build the result item
  // --------------------------------------------------------------------------
  always_comb begin
    front_idx_d = front_idx_q;
    rear_idx_d  = rear_idx_q;
    empty_d     = empty_q;
    front_val_d = front_val_q;
    rear_val_d  = rear_val_q;
    popped_d    = popped_q;
    pop_front_d = pop_front_q;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = data_in;
    rd_en       = 1'b0;
    rd_addr     = '0;
    need_read   = 1'b0;
    res_load    = 1'b0;
    res_status  = STAT_DONE;

    if (state_q == ST_IDLE && accept) begin
      res_load = 1'b1;
      popped_d = '0;
      case (cmd) inside
        CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
          if (!empty_q && idx_next(rear_idx_q) == front_idx_q) begin
            // Full: refuse, leave state alone.
            res_status = STAT_FULL;
          end else if (empty_q) begin
            // First element always lands in slot zero.
            front_idx_d = '0;
            rear_idx_d  = '0;
            empty_d     = 1'b0;
            front_val_d = data_in;
            rear_val_d  = data_in;
            mem_we      = 1'b1;
            mem_waddr   = '0;
          end else if (cmd == CMD_PUSH_FRONT) begin
            front_idx_d = idx_prev(front_idx_q);
            front_val_d = data_in;
            mem_we      = 1'b1;
            mem_waddr   = idx_prev(front_idx_q);
          end else begin
            rear_idx_d = idx_next(rear_idx_q);
            rear_val_d = data_in;
            mem_we     = 1'b1;
            mem_waddr  = idx_next(rear_idx_q);
          end
        end
        CMD_POP_FRONT, CMD_POP_REAR: begin
          if (empty_q) begin
            res_status = STAT_POP_EMPTY;
          end else begin
            popped_d    = (cmd == CMD_POP_FRONT) ? front_val_q : rear_val_q;
            pop_front_d = (cmd == CMD_POP_FRONT);
            if (front_idx_q == rear_idx_q) begin
              // Last element gone: back to the empty state.
              front_idx_d = '0;
              rear_idx_d  = '0;
              empty_d     = 1'b1;
            end else begin
              // Fetch the new end element; result follows after the read.
              need_read = 1'b1;
              res_load  = 1'b0;
              rd_en     = 1'b1;
              if (cmd == CMD_POP_FRONT) begin
                front_idx_d = idx_next(front_idx_q);
                rd_addr     = idx_next(front_idx_q);
              end else begin
                rear_idx_d = idx_prev(rear_idx_q);
                rd_addr    = idx_prev(rear_idx_q);
              end
            end
          end
        end
        default: begin
          // Query and unused codes: report only.
        end
      endcase
    end else if (state_q == ST_READ && out_free) begin
      res_load = 1'b1;
      if (pop_front_q) begin
        front_val_d = rd_data_q;
      end else begin
        rear_val_d = rd_data_q;
      end
    end

    // Result from the post-operation state.
    res_d.pad          = '0;
    res_d.status       = res_status;
    res_d.popped_value = popped_d;
    res_d.front_value  = empty_d ? '0 : front_val_d;
    res_d.rear_value   = empty_d ? '0 : rear_val_d;
    res_d.is_full      = !empty_d && (idx_next(rear_idx_d) == front_idx_d);
    res_d.is_empty     = empty_d;
  end

  // Hold the result until taken; load a new one only into a free stage.
  always_comb begin
    if (res_load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end else begin
      m_valid_d = m_valid_q;
    end
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      front_idx_q <= '0;
      rear_idx_q  <= '0;
      empty_q     <= 1'b1;
      pop_front_q <= 1'b0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_idx_q <= front_idx_d;
      rear_idx_q  <= rear_idx_d;
      empty_q     <= empty_d;
      pop_front_q <= pop_front_d;
      m_valid_q   <= m_valid_d;
    end
  end

  // Payload: no reset needed.
  always_ff @(posedge clk_i) begin
    front_val_q <= front_val_d;
    rear_val_q  <= rear_val_d;
    popped_q    <= popped_d;
    if (res_load) begin
      res_q <= res_d;
    end
  end

  // Slot memory write and registered read.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = res_q;

endmodule

// ===== design/cdq_checker.sv =====
// ----------------------------------------------------------------------------
// cdq_checker
// Port-level checks on the circular deque result stream.
// ----------------------------------------------------------------------------
`include "circular_deque_top_defines.svh"

module cdq_checker
  import cdq_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  // [1:0] status, [33:2] popped, [65:34] front, [97:66] rear, [98] full, [99] empty
  input logic [M_TDATA_W-1:0] m_axis_tdata
);

  res_t res;
  assign res = res_t'(m_axis_tdata);

  // A deque is never full and empty at once.
  `CDQ_ASSERT_IMPL(a_full_xor_empty, m_axis_tvalid, !(res.is_full && res.is_empty))

  // An empty deque shows zero at both ends.
  `CDQ_ASSERT_IMPL(a_empty_ends_zero, m_axis_tvalid && res.is_empty,
                   res.front_value == '0 && res.rear_value == '0)

  // A refused operation removes nothing.
  `CDQ_ASSERT_IMPL(a_refused_no_pop, m_axis_tvalid && res.status != STAT_DONE,
                   res.popped_value == '0)

  // A stalled result holds.
  `CDQ_ASSERT_NEXT(a_result_holds, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind circular_deque_top cdq_checker u_cdq_checker (.*);

// ===== sim/tb_circular_deque_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_circular_deque_top
// Self-checking bench for the circular deque. A short table of directed items
// covers the empty and full edges, extreme values and the spare commands. It
// is followed by about 1300 random items whose push/pop mix swings the deque
// between empty and full. Each result item is checked field by field against
// a cycle-free model of the deque, under four idling patterns on the two
// streams.
// ----------------------------------------------------------------------------
module tb_circular_deque_top;
  import cdq_pkg::*;

  localparam int DEPTH        = 8;
  localparam int IDX_W        = $clog2(DEPTH);
  localparam int ITEMS_PHASE  = 325;
  localparam int CHUNK        = 50;
  localparam int TAIL_CYCLES  = 16;
  localparam int MAX_REPORTS  = 10;
  localparam realtime RUN_LIMIT = 2ms;

  // Commands 5 to 7 have no name in the package; the block treats them as a query.
  localparam logic [CMD_W-1:0] CMD_SPARE_LO  = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_MID = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI  = 3'd7;

  localparam logic [DATA_W-1:0] VAL_MAX  = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] VAL_MIN  = 32'h8000_0000;
  localparam logic [DATA_W-1:0] VAL_ONES = 32'hFFFF_FFFF;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [DATA_W-1:0]    s_axis_tdata  = '0;  // [31:0] data_in
  logic [CMD_W-1:0]     s_axis_tuser  = '0;  // [2:0] cmd
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // [1:0] status, [33:2] popped_value, [65:34] front_value,
  // [97:66] rear_value, [98] is_full, [99] is_empty, [103:100] zero
  logic [M_TDATA_W-1:0] m_axis_tdata;

  // Idle odds in percent, changed per phase by the stimulus process.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mismatch_cnt   = 0;

  // Results predicted for accepted input items, oldest first.
  res_t pending_res[$];

  // Bench copy of the deque contents.
  logic [DATA_W-1:0] dq_slot [DEPTH];
  logic [IDX_W-1:0]  dq_front = '0;
  logic [IDX_W-1:0]  dq_rear  = '0;
  logic              dq_empty = 1'b1;

  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [DATA_W-1:0] data;
    bit                fixed;  // use the typed-in result instead of the model
    res_t              res;
  } dir_row_t;

  dir_row_t dir_rows[$];

  always #4 clk_i = ~clk_i;

  circular_deque_top #(
    .DEPTH(DEPTH)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // --------------------------------------------------------------------------
  // Deque model
  // --------------------------------------------------------------------------
  function automatic logic [IDX_W-1:0] idx_next(logic [IDX_W-1:0] i);
    return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] idx_prev(logic [IDX_W-1:0] i);
    return (i == '0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
  endfunction

  function automatic logic dq_is_full();
    return !dq_empty && (idx_next(dq_rear) == dq_front);
  endfunction

  // Apply one command to the bench deque and return the result it yields.
  function automatic res_t predict_deque(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] data);
    res_t r;
    r        = '0;
    r.status = STAT_DONE;
    case (cmd)
      CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
        if (dq_is_full()) begin
          r.status = STAT_FULL;
        end else if (dq_empty) begin
          // First element always lands in slot zero.
          dq_front   = '0;
          dq_rear    = '0;
          dq_slot[0] = data;
          dq_empty   = 1'b0;
        end else if (cmd == CMD_PUSH_FRONT) begin
          dq_front          = idx_prev(dq_front);
          dq_slot[dq_front] = data;
        end else begin
          dq_rear          = idx_next(dq_rear);
          dq_slot[dq_rear] = data;
        end
      end
      CMD_POP_FRONT, CMD_POP_REAR: begin
        if (dq_empty) begin
          r.status = STAT_POP_EMPTY;
        end else begin
          r.popped_value = (cmd == CMD_POP_FRONT) ? dq_slot[dq_front] : dq_slot[dq_rear];
          if (dq_front == dq_rear) begin
            // Last element gone: back to the reset layout.
            dq_front = '0;
            dq_rear  = '0;
            dq_empty = 1'b1;
          end else if (cmd == CMD_POP_FRONT) begin
            dq_front = idx_next(dq_front);
          end else begin
            dq_rear = idx_prev(dq_rear);
          end
        end
      end
      default: ;  // query and spare commands leave the deque alone
    endcase
    r.front_value = dq_empty ? '0 : dq_slot[dq_front];
    r.rear_value  = dq_empty ? '0 : dq_slot[dq_rear];
    r.is_full     = dq_is_full();
    r.is_empty    = dq_empty;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Directed rows
  // --------------------------------------------------------------------------
  function automatic res_t mk_res(status_e st, logic [DATA_W-1:0] popped,
                                  logic [DATA_W-1:0] front, logic [DATA_W-1:0] rear,
                                  logic full, logic empty);
    res_t r;
    r              = '0;
    r.status       = st;
    r.popped_value = popped;
    r.front_value  = front;
    r.rear_value   = rear;
    r.is_full      = full;
    r.is_empty     = empty;
    return r;
  endfunction

  function automatic void add_row(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] data,
                                  bit fixed = 1'b0, res_t res = '0);
    dir_row_t row;
    row.cmd   = cmd;
    row.data  = data;
    row.fixed = fixed;
    row.res   = res;
    dir_rows.push_back(row);
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Offer one input item, hold it until accepted, then queue its result.
  task automatic send_item(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] data,
                           bit fixed = 1'b0, res_t fixed_res = '0);
    res_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    // Advance the model even for typed-in rows so later rows stay in step.
    predicted = predict_deque(cmd, data);
    pending_res.push_back(fixed ? fixed_res : predicted);
  endtask

  // Drop valid and hold until every queued result has come back.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return VAL_ONES;
      2:       return VAL_MIN;
      3:       return VAL_MAX;
      default: return $urandom;
    endcase
  endfunction

  // Pushes with the given odds, pops below 92 percent, the last 8 percent queries and spares.
  function automatic logic [CMD_W-1:0] pick_cmd(int push_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < push_pct) begin
      return $urandom_range(0, 1) ? CMD_PUSH_REAR : CMD_PUSH_FRONT;
    end else if (r < 92) begin
      return $urandom_range(0, 1) ? CMD_POP_REAR : CMD_POP_FRONT;
    end
    return CMD_W'($urandom_range(int'(CMD_QUERY), int'(CMD_SPARE_HI)));
  endfunction

  // --------------------------------------------------------------------------
  // Result side: check accepted result items, then randomize tready
  // --------------------------------------------------------------------------
  function automatic void note_mismatch(string field, logic [DATA_W-1:0] want,
                                        logic [DATA_W-1:0] got);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS)
      $display("%0t: %s mismatch, expected %h, got %h", $realtime, field, want, got);
  endfunction

  always @(posedge clk_i) begin : result_mon
    res_t got;
    res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = res_t'(m_axis_tdata);
      if (pending_res.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
          $display("%0t: result item with none expected, got %h", $realtime, m_axis_tdata);
      end else begin
        want = pending_res.pop_front();
        if (got.status != want.status)
          note_mismatch("status", DATA_W'(want.status), DATA_W'(got.status));
        if (got.popped_value != want.popped_value)
          note_mismatch("popped_value", want.popped_value, got.popped_value);
        if (got.front_value != want.front_value)
          note_mismatch("front_value", want.front_value, got.front_value);
        if (got.rear_value != want.rear_value)
          note_mismatch("rear_value", want.rear_value, got.rear_value);
        if (got.is_full !== want.is_full)
          note_mismatch("is_full", DATA_W'(want.is_full), DATA_W'(got.is_full));
        if (got.is_empty !== want.is_empty)
          note_mismatch("is_empty", DATA_W'(want.is_empty), DATA_W'(got.is_empty));
        if (got.pad !== want.pad)
          note_mismatch("pad", DATA_W'(want.pad), DATA_W'(got.pad));
      end
    end
    m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stim
    int send_tab[4];
    int recv_tab[4];
    int push_odds[5];
    int push_pct;
    send_tab  = '{0, 52, 0, 13};
    recv_tab  = '{0, 0, 52, 13};
    push_odds = '{75, 25, 50, 90, 10};
    push_pct  = 50;

    // Empty deque: query, both pops refused, a push/pop of one element, then one more push.
    add_row(CMD_QUERY, VAL_ONES, 1'b1, mk_res(STAT_DONE, '0, '0, '0, 1'b0, 1'b1));
    add_row(CMD_POP_FRONT, '0, 1'b1, mk_res(STAT_POP_EMPTY, '0, '0, '0, 1'b0, 1'b1));
    add_row(CMD_POP_REAR, '0, 1'b1, mk_res(STAT_POP_EMPTY, '0, '0, '0, 1'b0, 1'b1));
    add_row(CMD_PUSH_REAR, VAL_MIN, 1'b1, mk_res(STAT_DONE, '0, VAL_MIN, VAL_MIN, 1'b0, 1'b0));
    add_row(CMD_POP_FRONT, '0, 1'b1, mk_res(STAT_DONE, VAL_MIN, '0, '0, 1'b0, 1'b1));
    add_row(CMD_PUSH_FRONT, VAL_MAX, 1'b1, mk_res(STAT_DONE, '0, VAL_MAX, VAL_MAX, 1'b0, 1'b0));
    // Fill to full from both ends, wrapping the front index below zero.
    add_row(CMD_PUSH_FRONT, VAL_ONES);
    add_row(CMD_PUSH_REAR, '0);
    add_row(CMD_PUSH_REAR, 32'h5555_5555);
    add_row(CMD_PUSH_FRONT, 32'hAAAA_AAAA);
    add_row(CMD_PUSH_REAR, 32'h0000_0001);
    add_row(CMD_PUSH_FRONT, 32'h1234_5678);
    add_row(CMD_PUSH_REAR, 32'hDEAD_BEEF);
    // Full: both pushes refused, spare commands act as queries.
    add_row(CMD_PUSH_FRONT, 32'h0000_0003);
    add_row(CMD_PUSH_REAR, 32'h0000_0004);
    add_row(CMD_SPARE_LO, VAL_ONES);
    add_row(CMD_SPARE_MID, '0);
    add_row(CMD_SPARE_HI, VAL_ONES);
    // Drain from alternating ends down to empty.
    for (int i = 0; i < DEPTH; i++) add_row((i % 2) ? CMD_POP_REAR : CMD_POP_FRONT, VAL_ONES);

    // Hold reset, then release it once.
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) send_item(dir_rows[i].cmd, dir_rows[i].data, dir_rows[i].fixed,
                                    dir_rows[i].res);
    wait_drained();

    // Random part: one phase per idling pattern, push odds swung every chunk so
    // the deque keeps hitting both full and empty.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = send_tab[ph];
      recv_stall_pct = recv_tab[ph];
      for (int n = 0; n < ITEMS_PHASE; n++) begin
        if (n % CHUNK == 0) push_pct = push_odds[$urandom_range(0, 4)];
        send_item(pick_cmd(push_pct), pick_value());
      end
      // Pause the sender until every result of this phase is back.
      wait_drained();
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_res.size() == 0) begin
      $display("tb_circular_deque_top: done, clean");
    end else begin
      $display("tb_circular_deque_top: done, errors");
    end
    $finish;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin : watchdog
    #(RUN_LIMIT);
    $display("tb_circular_deque_top: done, errors");
    $finish;
  end

endmodule

// ===== circular_deque_top.f =====
+incdir+design
design/cdq_pkg.sv
design/circular_deque_top.sv
design/cdq_checker.sv
sim/tb_circular_deque_top.sv
